// ===== src/nbst_pkg.sv =====
`timescale 1ns / 1ps
// nbst_pkg: shared types and constants of the flash block status table
// no dependencies

package nbst_pkg;

	localparam int BLOCK_W = 10;
	localparam int LIM_W   = 11;
	localparam int WEAR_W  = 16;
	localparam int TOT_W   = 26;

	localparam logic [2:0] CMD_QUERY     = 3'd0;
	localparam logic [2:0] CMD_MARK_BAD  = 3'd1;
	localparam logic [2:0] CMD_MARK_RSV  = 3'd2;
	localparam logic [2:0] CMD_CLEAR_RSV = 3'd3;
	localparam logic [2:0] CMD_ERASED    = 3'd4;
	localparam logic [2:0] CMD_FIND_FREE = 3'd5;

	localparam logic [WEAR_W-1:0] WEAR_MAX    = 16'hFFFF;
	localparam logic [LIM_W-1:0]  TALLY11_MAX = 11'h7FF;
	localparam logic [TOT_W-1:0]  TALLY26_MAX = 26'h3FFFFFF;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [BLOCK_W-1:0] block;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [BLOCK_W-1:0] found_block;
		logic               is_bad;
		logic               is_reserved;
		logic [WEAR_W-1:0]  block_wear;
		logic [LIM_W-1:0]   num_bad;
		logic [LIM_W-1:0]   num_reserved;
		logic [TOT_W-1:0]   erase_total;
	} result_t;

	// one stored entry per block
	typedef struct packed {
		logic              bad;
		logic              reserved;
		logic [WEAR_W-1:0] wear;
	} entry_t;

	typedef struct packed {
		logic [LIM_W-1:0] bad_cnt;
		logic [LIM_W-1:0] rsv_cnt;
		logic [TOT_W-1:0] erase_cnt;
	} tally_t;

endpackage

// ===== src/nbst_ram.sv =====
`timescale 1ns / 1ps
// nbst_ram: block entry store, one write and one registered read port
// depends on nbst_pkg

module nbst_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  nbst_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output nbst_pkg::entry_t rdata
);

	nbst_pkg::entry_t mem [DEPTH];
	nbst_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/nbst_update.sv =====
`timescale 1ns / 1ps
// nbst_update: modify step of the read-modify-write on one entry and the totals
// depends on nbst_pkg

module nbst_update (
	input  logic [2:0]       cmd,
	input  nbst_pkg::entry_t cur,
	input  nbst_pkg::tally_t tal,
	output nbst_pkg::entry_t nxt,
	output nbst_pkg::tally_t tal_nxt,
	output logic             wr
);

	always_comb begin
		nxt     = cur;
		tal_nxt = tal;
		wr      = 1'b0;
		case (cmd)
			nbst_pkg::CMD_MARK_BAD: begin
				wr      = 1'b1;
				nxt.bad = 1'b1;
				if (!cur.bad && tal.bad_cnt != nbst_pkg::TALLY11_MAX) begin
					tal_nxt.bad_cnt = tal.bad_cnt + 11'd1;
				end
			end
			nbst_pkg::CMD_MARK_RSV: begin
				wr           = 1'b1;
				nxt.reserved = 1'b1;
				if (!cur.reserved && tal.rsv_cnt != nbst_pkg::TALLY11_MAX) begin
					tal_nxt.rsv_cnt = tal.rsv_cnt + 11'd1;
				end
			end
			nbst_pkg::CMD_CLEAR_RSV: begin
				wr           = 1'b1;
				nxt.reserved = 1'b0;
				if (cur.reserved && tal.rsv_cnt != '0) begin
					tal_nxt.rsv_cnt = tal.rsv_cnt - 11'd1;
				end
			end
			nbst_pkg::CMD_ERASED: begin
				wr = 1'b1;
				// saturated wear leaves both count and total alone
				if (cur.wear != nbst_pkg::WEAR_MAX) begin
					nxt.wear = cur.wear + 16'd1;
					if (tal.erase_cnt != nbst_pkg::TALLY26_MAX) begin
						tal_nxt.erase_cnt = tal.erase_cnt + 26'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/nand_block_status_table_top.sv =====
`timescale 1ns / 1ps
// nand_block_status_table_top: flash block status table, controller and totals
// depends on nbst_pkg, nbst_ram, nbst_update
//
//  channel   ports                 direction  transaction taken when
//  --------  --------------------  ---------  --------------------------------
//  command   start, busy, item     in         rising edge with start high, busy low
//  result    done, result          out        the one cycle done is high
//  config    cfg_we, cfg_wdata     in         rising edge with cfg_we high
//
// query, mark and erase commands read the entry from the store when taken and
// write back a changed entry in the read state, where the result is registered,
// so a new command can be taken only once busy has fallen again.
// find free reads one entry a cycle from the start index up to the limit in
// effect; the one read port of the store sets this rate.
// after reset a clearing pass zeroes every entry of the store, one entry a
// cycle, with busy high; config writes are taken meanwhile.
// the receiver cannot stall: done is a one-cycle strobe from a register.

module nand_block_status_table_top #(
	parameter int NUM_BLOCKS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  nbst_pkg::item_t              item,
	output logic                         done,
	output nbst_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [nbst_pkg::LIM_W-1:0]   cfg_wdata
);

	// block indices are 10 bits, so no more than 1024 entries are reachable
	localparam int DEPTH = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

	state_t                      state_q;
	logic [AW-1:0]               clr_q;
	logic                        done_q;
	nbst_pkg::tally_t            tal_q;
	logic [nbst_pkg::LIM_W-1:0]  cfg_q;

	// per-transaction payload
	logic [2:0]                  cmd_q;
	logic [nbst_pkg::BLOCK_W-1:0] cur_q;
	logic                        inr_q;
	nbst_pkg::entry_t            start_q;
	nbst_pkg::result_t           result_q;

	logic [nbst_pkg::LIM_W-1:0]  lim;
	logic                        accept;
	logic                        in_inr;
	logic [nbst_pkg::LIM_W-1:0]  nxt_idx;
	logic                        is_find;
	logic                        cont;
	logic                        finish;
	logic                        known;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	nbst_pkg::entry_t            ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	nbst_pkg::entry_t            rdata;

	nbst_pkg::entry_t            upd_entry;
	nbst_pkg::tally_t            upd_tal;
	logic                        upd_wr;

	nbst_pkg::entry_t            start_entry;
	nbst_pkg::entry_t            oor_entry;
	nbst_pkg::entry_t            shown;
	nbst_pkg::tally_t            tal_sel;
	nbst_pkg::result_t           result_nxt;

	nbst_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	nbst_update u_update (
		.cmd     (cmd_q),
		.cur     (rdata),
		.tal     (tal_q),
		.nxt     (upd_entry),
		.tal_nxt (upd_tal),
		.wr      (upd_wr)
	);

	// limit in effect: register clamped to the store depth
	assign lim     = (cfg_q > nbst_pkg::LIM_W'(DEPTH)) ? nbst_pkg::LIM_W'(DEPTH) : cfg_q;
	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign in_inr  = ({1'b0, item.block} < lim);
	assign nxt_idx = {1'b0, cur_q} + 11'd1;
	assign is_find = (cmd_q == nbst_pkg::CMD_FIND_FREE);

	// scan goes on while the entry just read is bad and there is a next one
	assign cont   = (state_q == ST_READ || state_q == ST_SCAN) && is_find && inr_q &&
	                rdata.bad && (nxt_idx < lim);
	assign finish = (state_q == ST_READ || state_q == ST_SCAN) && !cont;

	always_comb begin
		case (cmd_q) inside
			nbst_pkg::CMD_QUERY, nbst_pkg::CMD_MARK_BAD, nbst_pkg::CMD_MARK_RSV,
			nbst_pkg::CMD_CLEAR_RSV, nbst_pkg::CMD_ERASED: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// store ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q[AW-1:0];
		ram_wdata = upd_entry;
		ram_re    = 1'b0;
		ram_raddr = nxt_idx[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re    = accept && in_inr;
				ram_raddr = item.block[AW-1:0];
			end
			ST_READ: begin
				ram_we = inr_q && upd_wr;
				ram_re = cont;
			end
			ST_SCAN: begin
				ram_re = cont;
			end
			default: begin
			end
		endcase
	end

	// result assembly
	always_comb begin
		oor_entry          = '0;
		oor_entry.bad      = 1'b1;
		start_entry        = (state_q == ST_READ) ? rdata : start_q;
		result_nxt         = '0;
		tal_sel            = tal_q;
		shown              = oor_entry;
		if (is_find) begin
			if (inr_q && !rdata.bad) begin
				result_nxt.found_block = cur_q;
				shown                  = rdata;
			end else begin
				// nothing free: report the start block as a query would
				result_nxt.status = 1'b1;
				shown             = inr_q ? start_entry : oor_entry;
			end
		end else begin
			result_nxt.status = !inr_q || !known;
			if (inr_q) begin
				shown   = upd_entry;
				tal_sel = upd_tal;
			end
		end
		result_nxt.is_bad       = shown.bad;
		result_nxt.is_reserved  = shown.reserved;
		result_nxt.block_wear   = shown.wear;
		result_nxt.num_bad      = tal_sel.bad_cnt;
		result_nxt.num_reserved = tal_sel.rsv_cnt;
		result_nxt.erase_total  = tal_sel.erase_cnt;
	end

	// control state and registered strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			tal_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ, ST_SCAN: begin
					if (cont) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						tal_q   <= tal_sel;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 11'd1024;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.cmd;
			cur_q <= item.block;
			inr_q <= in_inr;
		end
		if (state_q == ST_READ) begin
			start_q <= rdata;
		end
		if (cont) begin
			cur_q <= nxt_idx[nbst_pkg::BLOCK_W-1:0];
		end
		if (finish) begin
			result_q <= result_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/nbst_checker.sv =====
`timescale 1ns / 1ps
// nbst_checker: port-level checks on the block status table, with its bind
// depends on nbst_pkg and nand_block_status_table_top

module nbst_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input nbst_pkg::result_t result
);

	// each transaction passes through the read state, so strobes never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// a reserved block implies a non-zero reserved total
	a_rsv_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_reserved) |-> (result.num_reserved != '0))
		else $error("reserved block shown with zero reserved total");

	// an in-range bad block implies a non-zero bad total
	a_bad_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_bad && !result.status) |-> (result.num_bad != '0))
		else $error("bad block shown with zero bad total");

	a_wear_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.block_wear != '0)) |-> (result.erase_total != '0))
		else $error("worn block shown with zero erase total");

endmodule

bind nand_block_status_table_top nbst_checker u_nbst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
